[hdl/ialu_pkg.sv]
// ----------------------------------------------------------------------------
// Integer ALU package
// Opcodes and sequencer states shared by the integer ALU with power.
// ----------------------------------------------------------------------------
package ialu_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned StepW = 6;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_POW = 4'd5,
    OP_LT  = 4'd6,
    OP_LE  = 4'd7,
    OP_GT  = 4'd8,
    OP_GE  = 4'd9,
    OP_EQ  = 4'd10,
    OP_NE  = 4'd11,
    OP_NEG = 4'd12
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ABS,
    ST_DIV,
    ST_FIX,
    ST_MUL,
    ST_POW
  } state_e;

endpackage

[hdl/integer_alu_with_power.sv]
// ----------------------------------------------------------------------------
// Integer ALU with power
// 64-bit signed add, subtract, multiply, divide, remainder, power, negate
// and compare, with multiply and divide worked one bit per cycle.
// ----------------------------------------------------------------------------
// Usage: a request is taken at a rising edge where start is high and busy
// is low; op_i, left_operand_i and right_operand_i are sampled there. busy
// stays high until the result is ready. The result stands on result_value_o,
// is_truth_o and status_o for one cycle with done_o high; busy is already
// low in that cycle, so a new request may be issued alongside it.
// Add, subtract, negate and compares finish in ST_EXEC. Divide and
// remainder run ST_ABS, one ST_DIV step per quotient bit, then ST_FIX;
// a zero divisor ends in ST_EXEC. Multiply ends once the remaining
// multiplier bits are zero. Power runs one multiply per set exponent bit
// and one squaring per exponent bit. All of it runs on the shared
// one-bit-per-cycle shift-and-add datapath built around a single 64-bit adder.
// Reset clears the sequencer and done_o; the block is ready right after.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module integer_alu_with_power
  import ialu_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [3:0]              op_i,
  input  logic signed [DataW-1:0] left_operand_i,
  input  logic signed [DataW-1:0] right_operand_i,
  output logic                    done_o,
  output logic signed [DataW-1:0] result_value_o,
  output logic                    is_truth_o,
  output logic                    status_o
);

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [DataW-1:0]  a_q, a_d;
  logic [DataW-1:0]  b_q, b_d;
  // x holds the multiplicand or divisor, y the multiplier or partial
  // remainder, z the product or the dividend turning into the quotient.
  logic [DataW-1:0]  x_q, x_d;
  logic [DataW-1:0]  y_q, y_d;
  logic [DataW-1:0]  z_q, z_d;
  logic [DataW-1:0]  res_q, res_d;
  logic [StepW-1:0]  cnt_q, cnt_d;
  logic              sqr_q, sqr_d;
  logic              done_q, done_d;
  logic              truth_q, truth_d;
  logic              status_q, status_d;

  logic [DataW-1:0]  add_x, add_y;
  logic              add_c;
  logic [DataW:0]    sum;
  logic [DataW-1:0]  shifted;
  logic              lt, eq;

  assign shifted = {y_q[DataW-2:0], z_q[DataW-1]};
  assign sum     = {1'b0, add_x} + {1'b0, add_y} + {{DataW{1'b0}}, add_c};

  // Operand selection for the one shared adder.
  always_comb begin
    add_x = a_q;
    add_y = ~b_q;
    add_c = 1'b1;
    case (state_q)
      ST_EXEC: begin
        case (op_q)
          OP_ADD: begin
            add_y = b_q;
            add_c = 1'b0;
          end
          OP_NEG: begin
            add_x = ~a_q;
            add_y = '0;
          end
          OP_DIV, OP_MOD: begin
            add_x = ~b_q;
            add_y = '0;
          end
          default: ;
        endcase
      end
      ST_ABS: begin
        add_x = ~a_q;
        add_y = '0;
      end
      ST_DIV: begin
        add_x = shifted;
        add_y = ~x_q;
      end
      ST_FIX: begin
        add_x = (op_q == OP_DIV) ? ~z_q : ~y_q;
        add_y = '0;
      end
      ST_MUL: begin
        add_x = z_q;
        add_y = x_q;
        add_c = 1'b0;
      end
      default: ;
    endcase
  end

  // Signed compare from the difference a - b.
  assign lt = (a_q[DataW-1] != b_q[DataW-1]) ? a_q[DataW-1] : sum[DataW-1];
  assign eq = (a_q == b_q);

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    a_d      = a_q;
    b_d      = b_q;
    x_d      = x_q;
    y_d      = y_q;
    z_d      = z_q;
    res_d    = res_q;
    cnt_d    = cnt_q;
    sqr_d    = sqr_q;
    done_d   = 1'b0;
    truth_d  = truth_q;
    status_d = status_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_d    = op_e'(op_i);
          a_d     = left_operand_i;
          b_d     = right_operand_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        truth_d  = 1'b0;
        status_d = 1'b0;
        res_d    = '0;
        done_d   = 1'b1;
        state_d  = ST_IDLE;
        case (op_q)
          OP_ADD, OP_SUB, OP_NEG: res_d = sum[DataW-1:0];
          OP_LT: begin
            res_d   = DataW'(lt);
            truth_d = 1'b1;
          end
          OP_LE: begin
            res_d   = DataW'(lt | eq);
            truth_d = 1'b1;
          end
          OP_GT: begin
            res_d   = DataW'(!(lt | eq));
            truth_d = 1'b1;
          end
          OP_GE: begin
            res_d   = DataW'(!lt);
            truth_d = 1'b1;
          end
          OP_EQ: begin
            res_d   = DataW'(eq);
            truth_d = 1'b1;
          end
          OP_NE: begin
            res_d   = DataW'(!eq);
            truth_d = 1'b1;
          end
          OP_MUL: begin
            x_d     = a_q;
            y_d     = b_q;
            z_d     = '0;
            done_d  = 1'b0;
            state_d = ST_MUL;
          end
          OP_DIV, OP_MOD: begin
            if (b_q == '0) begin
              status_d = 1'b1;
            end else begin
              x_d     = b_q[DataW-1] ? sum[DataW-1:0] : b_q;
              done_d  = 1'b0;
              state_d = ST_ABS;
            end
          end
          OP_POW: begin
            res_d = DataW'(1);
            if (!b_q[DataW-1]) begin
              done_d  = 1'b0;
              state_d = ST_POW;
            end
          end
          default: ;
        endcase
      end
      ST_ABS: begin
        z_d     = a_q[DataW-1] ? sum[DataW-1:0] : a_q;
        y_d     = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // The carry out of shifted + ~divisor + 1 says the divisor fits.
        y_d   = sum[DataW] ? sum[DataW-1:0] : shifted;
        z_d   = {z_q[DataW-2:0], sum[DataW]};
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q == {StepW{1'b1}}) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        if (op_q == OP_DIV) begin
          res_d = (a_q[DataW-1] ^ b_q[DataW-1]) ? sum[DataW-1:0] : z_q;
        end else begin
          res_d = a_q[DataW-1] ? sum[DataW-1:0] : y_q;
        end
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_MUL: begin
        if (y_q == '0) begin
          if (op_q == OP_MUL) begin
            res_d   = z_q;
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else if (sqr_q) begin
            a_d     = z_q;
            b_d     = {1'b0, b_q[DataW-1:1]};
            state_d = ST_POW;
          end else begin
            // Accumulator updated; square the base next.
            res_d = z_q;
            x_d   = a_q;
            y_d   = a_q;
            z_d   = '0;
            sqr_d = 1'b1;
          end
        end else begin
          if (y_q[0]) begin
            z_d = sum[DataW-1:0];
          end
          x_d = {x_q[DataW-2:0], 1'b0};
          y_d = {1'b0, y_q[DataW-1:1]};
        end
      end
      ST_POW: begin
        z_d = '0;
        if (b_q == '0) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else if (b_q[0]) begin
          x_d     = res_q;
          y_d     = a_q;
          sqr_d   = 1'b0;
          state_d = ST_MUL;
        end else begin
          x_d     = a_q;
          y_d     = a_q;
          sqr_d   = 1'b1;
          state_d = ST_MUL;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    a_q      <= a_d;
    b_q      <= b_d;
    x_q      <= x_d;
    y_q      <= y_d;
    z_q      <= z_d;
    res_q    <= res_d;
    cnt_q    <= cnt_d;
    sqr_q    <= sqr_d;
    truth_q  <= truth_d;
    status_q <= status_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign is_truth_o     = truth_q;
  assign status_o       = status_q;

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// Integer ALU with power testbench
// Sends directed corner cases, then random requests, to the integer ALU with
// idle bursts between them. Each accepted request is run through a local
// model of the ALU, and each done_o result is checked against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_top
  import ialu_pkg::*;
();

  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [3:0]  OP_RSVD_FIRST = 4'd13;
  localparam logic [3:0]  OP_RSVD_LAST  = 4'd15;
  localparam int unsigned RAND_REQS     = 925;
  localparam int unsigned LONG_POW_MAX  = 12;
  localparam int unsigned CALM_TAIL     = 150;

  typedef struct packed {
    logic [3:0]  op;
    logic [63:0] lhs;
    logic [63:0] rhs;
  } alu_req_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [63:0] value;
    logic        truth;
    logic        status;
  } alu_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [3:0]              op_i = '0;
  logic signed [DataW-1:0] left_operand_i = '0;
  logic signed [DataW-1:0] right_operand_i = '0;
  logic                    done_o;
  logic signed [DataW-1:0] result_value_o;
  logic                    is_truth_o;
  logic                    status_o;

  alu_req_t    pending_reqs[$];
  alu_result_t expected_results[$];
  alu_req_t    next_req;
  alu_result_t want;

  int unsigned total_reqs = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked = 0;
  int unsigned n_compares = 0;
  int unsigned n_zero_div = 0;
  int unsigned n_long_pow = 0;
  int unsigned n_errors = 0;
  int unsigned gap_left = 0;
  int unsigned idle_level = 2;

  integer_alu_with_power dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .op_i            (op_i),
    .left_operand_i  (left_operand_i),
    .right_operand_i (right_operand_i),
    .done_o          (done_o),
    .result_value_o  (result_value_o),
    .is_truth_o      (is_truth_o),
    .status_o        (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Expected outcome of one request; arithmetic wraps at 64 bits.
  function automatic alu_result_t alu_compute(logic [3:0] op, logic [63:0] a,
                                              logic [63:0] b);
    alu_result_t r;
    logic [63:0] ua, ub, base, expo, acc;
    r = '0;
    r.op = op;
    case (op)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: r.value = a * b;
      OP_DIV, OP_MOD: begin
        if (b == '0) begin
          r.status = 1'b1;
        end else begin
          ua = a[63] ? -a : a;
          ub = b[63] ? -b : b;
          if (op == OP_DIV) begin
            r.value = ua / ub;
            if (a[63] ^ b[63]) r.value = -r.value;
          end else begin
            r.value = ua % ub;
            if (a[63]) r.value = -r.value;
          end
        end
      end
      OP_POW: begin
        acc = 64'd1;
        if (!b[63]) begin
          base = a;
          expo = b;
          for (int i = 0; i < 63; i++) begin
            if (expo[0]) acc = acc * base;
            base = base * base;
            expo = expo >> 1;
          end
        end
        r.value = acc;
      end
      OP_LT: begin
        r.value = {63'd0, $signed(a) < $signed(b)};
        r.truth = 1'b1;
      end
      OP_LE: begin
        r.value = {63'd0, $signed(a) <= $signed(b)};
        r.truth = 1'b1;
      end
      OP_GT: begin
        r.value = {63'd0, $signed(a) > $signed(b)};
        r.truth = 1'b1;
      end
      OP_GE: begin
        r.value = {63'd0, $signed(a) >= $signed(b)};
        r.truth = 1'b1;
      end
      OP_EQ: begin
        r.value = {63'd0, a == b};
        r.truth = 1'b1;
      end
      OP_NE: begin
        r.value = {63'd0, a != b};
        r.truth = 1'b1;
      end
      OP_NEG: r.value = -a;
      default: r.value = '0;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 64'd1;
      2: return '1;
      3: return MIN64;
      4: return MAX64;
      5: return {56'd0, 8'($urandom)} - 64'd128;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_req(logic [3:0] op, logic [63:0] lhs, logic [63:0] rhs);
    alu_req_t r;
    r.op = op;
    r.lhs = lhs;
    r.rhs = rhs;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic queue_random_req();
    logic [3:0]  op;
    logic [63:0] lhs, rhs;
    if ($urandom_range(0, 19) == 0) op = 4'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
    else op = 4'($urandom_range(OP_ADD, OP_NEG));
    lhs = pick_operand();
    rhs = pick_operand();
    case (op)
      OP_DIV, OP_MOD: if ($urandom_range(0, 7) == 0) rhs = '0;
      OP_POW: begin
        // Long exponents are slow, so at most LONG_POW_MAX of them are sent.
        if (n_long_pow < LONG_POW_MAX && $urandom_range(0, 15) == 0) begin
          rhs = {1'b0, 31'($urandom), $urandom};
          n_long_pow++;
        end else if ($urandom_range(0, 3) != 0) begin
          rhs = 64'($urandom_range(0, 70));
        end else begin
          rhs = rhs | MIN64;
        end
      end
      OP_LT, OP_LE, OP_GT, OP_GE, OP_EQ, OP_NE: if ($urandom_range(0, 3) == 0) rhs = lhs;
      default: ;
    endcase
    queue_req(op, lhs, rhs);
  endtask

  // Request driver: holds a request until the block takes it.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.insert(expected_results.size(),
                                alu_compute(op_i, left_operand_i, right_operand_i));
        n_accepted++;
        if (n_accepted % 64 == 0) idle_level = $urandom_range(0, 3);
        if (n_accepted + CALM_TAIL < total_reqs && idle_level != 0 &&
            $urandom_range(1, 8) <= idle_level)
          gap_left = $urandom_range(1, 17);
      end
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          next_req = pending_reqs.pop_front();
          op_i <= next_req.op;
          left_operand_i <= next_req.lhs;
          right_operand_i <= next_req.rhs;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got value %h truth %b status %b",
                 $time, result_value_o, is_truth_o, status_o);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (want.truth) n_compares++;
        if (want.status) n_zero_div++;
        if (result_value_o !== want.value) begin
          $display("%0t: op %0d result_value: expected %h, got %h",
                   $time, want.op, want.value, result_value_o);
          n_errors++;
        end
        if (is_truth_o !== want.truth) begin
          $display("%0t: op %0d is_truth: expected %b, got %b",
                   $time, want.op, want.truth, is_truth_o);
          n_errors++;
        end
        if (status_o !== want.status) begin
          $display("%0t: op %0d status: expected %b, got %b",
                   $time, want.op, want.status, status_o);
          n_errors++;
        end
      end
    end
  end

  initial begin
    // Wrapping add, subtract, multiply and negate.
    queue_req(OP_ADD, MAX64, 64'd1);
    queue_req(OP_ADD, MIN64, '1);
    queue_req(OP_SUB, MIN64, 64'd1);
    queue_req(OP_MUL, MAX64, MAX64);
    queue_req(OP_MUL, MIN64, '1);
    queue_req(OP_NEG, MIN64, MAX64);
    queue_req(OP_NEG, '0, '1);
    // Signed division and remainder, including zero divisors and min / -1.
    queue_req(OP_DIV, 64'd7, -64'd2);
    queue_req(OP_DIV, -64'd7, 64'd2);
    queue_req(OP_DIV, MIN64, '1);
    queue_req(OP_DIV, MAX64, '0);
    queue_req(OP_MOD, -64'd7, 64'd2);
    queue_req(OP_MOD, 64'd7, -64'd2);
    queue_req(OP_MOD, MIN64, '1);
    queue_req(OP_MOD, MIN64, '0);
    // Power: zero and negative exponents give one.
    queue_req(OP_POW, -64'd3, 64'd5);
    queue_req(OP_POW, '0, '0);
    queue_req(OP_POW, 64'd2, MIN64);
    queue_req(OP_POW, 64'd3, MAX64);
    queue_req(OP_LT, MIN64, MAX64);
    queue_req(OP_LE, MAX64, MAX64);
    queue_req(OP_GT, MIN64, MAX64);
    queue_req(OP_GE, '1, '0);
    queue_req(OP_EQ, MIN64, MIN64);
    queue_req(OP_NE, '0, MIN64);
    queue_req(OP_RSVD_FIRST, MAX64, 64'd1);
    queue_req(OP_RSVD_LAST, MIN64, MIN64);
    repeat (RAND_REQS) queue_random_req();
    total_reqs = pending_reqs.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < total_reqs) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Checked %0d results for %0d requests across all opcodes and unused codes.",
             n_checked, total_reqs);
    $display("Of these %0d were compares, %0d zero divisors, %0d long-exponent powers.",
             n_compares, n_zero_div, n_long_pow);
    if (n_errors == 0) begin
      $display("integer_alu_with_power test passed");
    end else begin
      $display("integer_alu_with_power test failed");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Timed out with %0d of %0d requests accepted.", n_accepted, total_reqs);
    $display("integer_alu_with_power test failed");
    $finish;
  end

endmodule
